// ===== rtl/dwsp_pkg.sv =====
// shared types, constants and the idle timeout table for the display wake/sleep policy
// no dependencies; imported by every module of the block
`default_nettype none

package dwsp_pkg;

    localparam int TimeW = 64;

    // item kinds
    localparam logic [1:0] KIND_STEP     = 2'd0;
    localparam logic [1:0] KIND_PAIRING  = 2'd1;
    localparam logic [1:0] KIND_RECONCILE = 2'd2;
    localparam logic [1:0] KIND_FAILURE  = 2'd3;

    // intents
    localparam logic [2:0] INTENT_NONE  = 3'd0;
    localparam logic [2:0] INTENT_WAKE  = 3'd1;
    localparam logic [2:0] INTENT_SLEEP = 3'd2;
    localparam logic [2:0] INTENT_NEXT  = 3'd3;
    localparam logic [2:0] INTENT_STOP  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_IDLE_CHOICE  = 2'd0;
    localparam logic [1:0] CFG_PAIRING_TO   = 2'd1;
    localparam logic [1:0] CFG_INIT_DISPLAY = 2'd2;
    localparam logic [1:0] CFG_UNUSED       = 2'd3;

    // timeout choice codes
    localparam logic [1:0] TO_5S  = 2'd0;
    localparam logic [1:0] TO_15S = 2'd1;
    localparam logic [1:0] TO_30S = 2'd2;

    localparam logic [1:0]  CHOICE_RESET     = TO_15S;
    localparam logic [15:0] PAIRING_TO_RESET = 16'd30000;
    localparam logic        INIT_ON_RESET    = 1'b1;

    typedef struct packed {
        logic [1:0]       kind;
        logic [TimeW-1:0] time_ms;
        logic             stop_request;
        logic             selftest_known;
        logic             selftest_on;
        logic             user_activity;
        logic             button_valid;
        logic             button_pressed;
        logic             wrist_lift;
        logic             flag_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0] intent;
        logic       display_is_on;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  idle_timeout_choice;
        logic [15:0] pairing_page_timeout_ms;
        logic        initial_display_on;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic value;
    } t_disp_load;

    typedef struct packed {
        logic             stop_latched;
        logic             display_on_state;
        logic [TimeW-1:0] last_activity_time;
        logic             pairing_page_active;
        logic             selftest_running;
        logic             selftest_entry_display;
        logic             selftest_user_seen;
        logic             selftest_wake_blocked;
        logic             button_known;
        logic             button_down;
        logic             press_began_display_on;
        logic             release_blocked;
    } t_state;

    // policy state right after reset
    localparam t_state STATE_RESET = '{
        stop_latched:           1'b0,
        display_on_state:       INIT_ON_RESET,
        last_activity_time:     '0,
        pairing_page_active:    1'b0,
        selftest_running:       1'b0,
        selftest_entry_display: 1'b0,
        selftest_user_seen:     1'b0,
        selftest_wake_blocked:  1'b0,
        button_known:           1'b0,
        button_down:            1'b0,
        press_began_display_on: 1'b0,
        release_blocked:        1'b0
    };

    function automatic logic [15:0] timeout_for_choice(input logic [1:0] choice);
        logic [15:0] v;
        case (choice)
            TO_5S:   v = 16'd5000;
            TO_15S:  v = 16'd15000;
            TO_30S:  v = 16'd30000;
            default: v = 16'd15000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dwsp_cfg.sv =====
// configuration registers of the display wake/sleep policy
// depends on dwsp_pkg
`default_nettype none

module dwsp_cfg (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [15:0]         i_cfg_data,
    output dwsp_pkg::t_cfg           o_cfg,
    output dwsp_pkg::t_disp_load     o_disp_load
);
    import dwsp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_timeout_choice     <= CHOICE_RESET;
            r_cfg.pairing_page_timeout_ms <= PAIRING_TO_RESET;
            r_cfg.initial_display_on      <= INIT_ON_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IDLE_CHOICE: begin
                    // unused choice code leaves the register alone
                    if (i_cfg_data[1:0] != 2'd3) begin
                        r_cfg.idle_timeout_choice <= i_cfg_data[1:0];
                    end
                end
                CFG_PAIRING_TO:   r_cfg.pairing_page_timeout_ms <= i_cfg_data;
                CFG_INIT_DISPLAY: r_cfg.initial_display_on <= i_cfg_data[0];
                CFG_UNUSED: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg             = r_cfg;
    assign o_disp_load.load  = i_cfg_valid && (i_cfg_index == CFG_INIT_DISPLAY);
    assign o_disp_load.value = i_cfg_data[0];

endmodule

`default_nettype wire

// ===== rtl/dwsp_step.sv =====
// next-state and intent logic for one item of the display wake/sleep policy
// depends on dwsp_pkg
`default_nettype none

module dwsp_step (
    input  wire dwsp_pkg::t_in_item  i_item,
    input  wire dwsp_pkg::t_state    i_state,
    input  wire dwsp_pkg::t_cfg      i_cfg,
    output dwsp_pkg::t_state         o_state,
    output logic [2:0]               o_intent
);
    import dwsp_pkg::*;

    t_state           s;
    logic [2:0]       intent;
    logic [2:0]       btn_intent;
    logic             done;
    logic             press_now;
    logic             restore;
    logic             blocked;
    logic             began_on;
    logic [TimeW-1:0] diff;
    logic [TimeW-1:0] elapsed;
    logic [15:0]      limit;

    always_comb begin
        s          = i_state;
        intent     = INTENT_NONE;
        btn_intent = INTENT_NONE;
        done       = 1'b0;
        press_now  = i_item.button_valid && i_item.button_pressed;
        restore    = 1'b0;
        blocked    = 1'b0;
        began_on   = 1'b0;
        diff       = '0;
        elapsed    = '0;
        limit      = '0;

        case (i_item.kind)
            KIND_STEP: begin
                if (s.stop_latched) begin
                    done = 1'b1;
                end else if (i_item.stop_request) begin
                    s.stop_latched = 1'b1;
                    intent         = INTENT_STOP;
                    done           = 1'b1;
                end

                if (!done) begin
                    // self-test entry
                    if (i_item.selftest_known && i_item.selftest_on
                            && !s.selftest_running) begin
                        s.selftest_running       = 1'b1;
                        s.selftest_entry_display = s.display_on_state;
                        s.selftest_user_seen     = 1'b0;
                        s.selftest_wake_blocked  = 1'b0;
                        if (s.button_known && s.button_down) begin
                            s.release_blocked = 1'b1;
                        end
                    end
                    if (s.selftest_running && (i_item.user_activity || press_now)) begin
                        s.selftest_user_seen = 1'b1;
                        s.last_activity_time = i_item.time_ms;
                        if (press_now) begin
                            s.release_blocked = 1'b1;
                        end
                    end
                    // self-test exit
                    if (i_item.selftest_known && !i_item.selftest_on
                            && s.selftest_running) begin
                        restore                 = s.selftest_user_seen
                                                  || s.selftest_entry_display;
                        s.selftest_running      = 1'b0;
                        s.selftest_user_seen    = 1'b0;
                        s.selftest_wake_blocked = 1'b0;
                        if (restore) begin
                            s.last_activity_time = i_item.time_ms;
                        end
                        if (s.display_on_state != restore) begin
                            s.display_on_state = restore;
                            intent             = restore ? INTENT_WAKE : INTENT_SLEEP;
                            done               = 1'b1;
                        end
                    end
                end

                if (!done && s.selftest_running && !s.display_on_state
                        && !s.selftest_wake_blocked) begin
                    s.display_on_state = 1'b1;
                    intent             = INTENT_WAKE;
                    done               = 1'b1;
                end

                if (!done) begin
                    // power button tracking
                    if (!i_item.button_valid) begin
                        s.button_known           = 1'b0;
                        s.button_down            = 1'b0;
                        s.press_began_display_on = 1'b0;
                        s.release_blocked        = 1'b0;
                    end else if (!s.button_known) begin
                        s.button_known = 1'b1;
                        s.button_down  = i_item.button_pressed;
                        if (i_item.button_pressed) begin
                            s.last_activity_time     = i_item.time_ms;
                            s.press_began_display_on = s.display_on_state;
                            s.release_blocked        = s.selftest_running;
                        end
                    end else if (i_item.button_pressed != s.button_down) begin
                        s.button_down        = i_item.button_pressed;
                        s.last_activity_time = i_item.time_ms;
                        if (i_item.button_pressed) begin
                            s.press_began_display_on = s.display_on_state;
                            s.release_blocked        = s.selftest_running;
                        end else begin
                            began_on                 = s.press_began_display_on;
                            blocked                  = s.release_blocked;
                            s.press_began_display_on = 1'b0;
                            s.release_blocked        = 1'b0;
                            s.selftest_wake_blocked  = 1'b0;
                            if (!blocked && !s.display_on_state) begin
                                s.display_on_state = 1'b1;
                                btn_intent         = INTENT_WAKE;
                            end else if (!blocked && began_on && !s.selftest_running) begin
                                btn_intent = INTENT_NEXT;
                            end
                        end
                    end

                    if (i_item.user_activity) begin
                        s.selftest_wake_blocked = 1'b0;
                        s.last_activity_time    = i_item.time_ms;
                        if (!s.display_on_state) begin
                            s.display_on_state = 1'b1;
                            intent             = INTENT_WAKE;
                            done               = 1'b1;
                        end
                    end
                end

                if (!done && btn_intent != INTENT_NONE) begin
                    intent = btn_intent;
                    done   = 1'b1;
                end

                if (!done) begin
                    if (s.button_known && s.button_down) begin
                        s.last_activity_time = i_item.time_ms;
                    end
                    if (i_item.wrist_lift && !s.display_on_state && !s.selftest_running
                            && !(s.button_known && s.button_down)) begin
                        s.last_activity_time = i_item.time_ms;
                        s.display_on_state   = 1'b1;
                        intent               = INTENT_WAKE;
                        done                 = 1'b1;
                    end
                end

                if (!done) begin
                    // idle timeout; a backwards clock reads as zero idle time
                    limit   = s.pairing_page_active ? i_cfg.pairing_page_timeout_ms
                                                    : timeout_for_choice(i_cfg.idle_timeout_choice);
                    diff    = i_item.time_ms - s.last_activity_time;
                    elapsed = diff[TimeW-1] ? '0 : diff;
                    if (s.display_on_state && !s.selftest_running
                            && elapsed >= {{(TimeW-16){1'b0}}, limit}) begin
                        s.display_on_state = 1'b0;
                        intent             = INTENT_SLEEP;
                    end
                end
            end
            KIND_PAIRING: begin
                if (s.pairing_page_active != i_item.flag_value) begin
                    s.pairing_page_active = i_item.flag_value;
                    s.last_activity_time  = i_item.time_ms;
                end
            end
            KIND_RECONCILE: begin
                s.display_on_state = i_item.flag_value;
            end
            KIND_FAILURE: begin
                if (s.selftest_running && !s.display_on_state) begin
                    s.selftest_wake_blocked = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_state  = s;
    assign o_intent = intent;

endmodule

`default_nettype wire

// ===== rtl/display_wake_sleep_policy.sv =====
// display wake/sleep policy, top level: input register, step logic, result register
// depends on dwsp_pkg, dwsp_cfg and dwsp_step
//
// Decides wake, sleep, next-page and stop intents for a wearable display from
// timestamped items. Every accepted item gives exactly one result item, in
// order: a policy step gives its intent, the pairing-page, reconcile and
// failure-note kinds give intent none. Each result also carries the display
// state held after the item. Throughput is one item per clock while the sink
// takes results. A taken item waits in the input register and moves into the
// result register once that register is free or being taken (one input
// register, one result register). The step logic between them is flag logic
// plus one 64-bit wrapping subtract and compare against the active timeout.
// The block holds at most two items: the input is ready while the input
// register is empty or its item moves on in that cycle, which needs the
// result register free or being taken. Configuration writes are always ready
// and are meant to be issued while the block is idle; writing
// initial_display_on also loads the held display state.
`default_nettype none

module display_wake_sleep_policy (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // item input channel
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire dwsp_pkg::t_in_item  i_in_data,
    // result channel
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output dwsp_pkg::t_out_item      o_out_data,
    // configuration write channel
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [15:0]         i_cfg_data
);
    import dwsp_pkg::*;

    // input register
    logic       r_in_valid;
    t_in_item   r_in;
    // result register
    logic       r_out_valid;
    t_out_item  r_out;
    // policy state
    t_state     r_state;
    t_state     n_state;
    logic [2:0] step_intent;

    t_cfg       cfg;
    t_disp_load disp_load;
    logic       advance;
    logic       cfg_write;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    dwsp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_write),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_disp_load (disp_load)
    );

    dwsp_step u_step (
        .i_item   (r_in),
        .i_state  (r_state),
        .i_cfg    (cfg),
        .o_state  (n_state),
        .o_intent (step_intent)
    );

    // the held item moves into the result register when that register frees up
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.intent        <= step_intent;
            r_out.display_is_on <= n_state.display_on_state;
        end
    end

    // policy state; a write of initial_display_on also sets the display state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end else if (disp_load.load) begin
            r_state.display_on_state <= disp_load.value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/dwsp_checker.sv =====
// port-level checks for the display wake/sleep policy, bound to the top level
// depends on dwsp_pkg and display_wake_sleep_policy
`default_nettype none

module dwsp_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                o_in_ready,
    input  wire logic                o_out_valid,
    input  wire logic                i_out_ready,
    input  wire dwsp_pkg::t_out_item o_out_data
);
    import dwsp_pkg::*;

    // set once a stop result has been delivered
    logic r_stopped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stopped <= 1'b0;
        end else if (o_out_valid && i_out_ready && o_out_data.intent == INTENT_STOP) begin
            r_stopped <= 1'b1;
        end
    end

    // a result waiting for the sink holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // a free result side never blocks the input
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // wake, next page and sleep agree with the reported display state
    a_intent_display: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.intent == INTENT_WAKE || o_out_data.intent == INTENT_NEXT)
        |-> o_out_data.display_is_on)
        else $error("wake or next page with display off");

    a_sleep_display: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.intent == INTENT_SLEEP |-> !o_out_data.display_is_on)
        else $error("sleep with display on");

    // after stop every later result is intent none
    a_stopped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped && o_out_valid |-> o_out_data.intent == INTENT_NONE)
        else $error("intent given after stop");

endmodule

bind display_wake_sleep_policy dwsp_checker u_dwsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// ===== verif/dwsp_policy_checker.sv =====
// result checker for display_wake_sleep_policy: watches the item, result and config channels
// depends on dwsp_pkg for item types, intents, kinds and register indexes
`default_nettype none

module dwsp_policy_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_ready,
    input  wire dwsp_pkg::t_in_item  i_in_data,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_ready,
    input  wire dwsp_pkg::t_out_item i_out_data,
    input  wire logic                i_cfg_valid,
    input  wire logic                i_cfg_ready,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [15:0]         i_cfg_data,
    output int                       o_fail_count,
    output int                       o_outstanding,
    output int                       o_checked
);
    import dwsp_pkg::*;

    t_state      pol;
    logic [1:0]  choice_q;
    logic [15:0] pair_to_q;
    logic        init_on_q;

    t_out_item   expected_q[$];
    int          errors;
    int          checked;

    function automatic logic [63:0] active_limit();
        if (pol.pairing_page_active) return {48'd0, pair_to_q};
        case (choice_q)
            TO_5S:   return 64'd5000;
            TO_30S:  return 64'd30000;
            default: return 64'd15000;
        endcase
    endfunction

    // one policy step, priority: stop, self-test, activity, button, wrist, idle timeout
    function automatic logic [2:0] policy_intent(input t_in_item it);
        logic        press_now;
        logic        began_on;
        logic        blocked;
        logic        restore;
        logic [2:0]  btn;
        logic [63:0] idle;
        press_now = it.button_valid & it.button_pressed;
        btn = INTENT_NONE;
        if (pol.stop_latched) return INTENT_NONE;
        if (it.stop_request) begin
            pol.stop_latched = 1'b1;
            return INTENT_STOP;
        end
        if (it.selftest_known && it.selftest_on && !pol.selftest_running) begin
            pol.selftest_running       = 1'b1;
            pol.selftest_entry_display = pol.display_on_state;
            pol.selftest_user_seen     = 1'b0;
            pol.selftest_wake_blocked  = 1'b0;
            if (pol.button_known && pol.button_down) pol.release_blocked = 1'b1;
        end
        if (pol.selftest_running && (it.user_activity || press_now)) begin
            pol.selftest_user_seen = 1'b1;
            pol.last_activity_time = it.time_ms;
            if (press_now) pol.release_blocked = 1'b1;
        end
        if (it.selftest_known && !it.selftest_on && pol.selftest_running) begin
            restore = pol.selftest_user_seen | pol.selftest_entry_display;
            pol.selftest_running      = 1'b0;
            pol.selftest_user_seen    = 1'b0;
            pol.selftest_wake_blocked = 1'b0;
            if (restore) pol.last_activity_time = it.time_ms;
            if (pol.display_on_state != restore) begin
                pol.display_on_state = restore;
                return restore ? INTENT_WAKE : INTENT_SLEEP;
            end
        end
        if (pol.selftest_running && !pol.display_on_state && !pol.selftest_wake_blocked) begin
            pol.display_on_state = 1'b1;
            return INTENT_WAKE;
        end
        if (!it.button_valid) begin
            pol.button_known           = 1'b0;
            pol.button_down            = 1'b0;
            pol.press_began_display_on = 1'b0;
            pol.release_blocked        = 1'b0;
        end else if (!pol.button_known) begin
            pol.button_known = 1'b1;
            pol.button_down  = it.button_pressed;
            if (it.button_pressed) begin
                pol.last_activity_time     = it.time_ms;
                pol.press_began_display_on = pol.display_on_state;
                pol.release_blocked        = pol.selftest_running;
            end
        end else if (it.button_pressed != pol.button_down) begin
            pol.button_down        = it.button_pressed;
            pol.last_activity_time = it.time_ms;
            if (it.button_pressed) begin
                pol.press_began_display_on = pol.display_on_state;
                pol.release_blocked        = pol.selftest_running;
            end else begin
                began_on = pol.press_began_display_on;
                blocked  = pol.release_blocked;
                pol.press_began_display_on = 1'b0;
                pol.release_blocked        = 1'b0;
                pol.selftest_wake_blocked  = 1'b0;
                if (!blocked && !pol.display_on_state) begin
                    pol.display_on_state = 1'b1;
                    btn = INTENT_WAKE;
                end else if (!blocked && began_on && !pol.selftest_running) begin
                    btn = INTENT_NEXT;
                end
            end
        end
        if (it.user_activity) begin
            pol.selftest_wake_blocked = 1'b0;
            pol.last_activity_time    = it.time_ms;
            if (!pol.display_on_state) begin
                pol.display_on_state = 1'b1;
                return INTENT_WAKE;
            end
        end
        if (btn != INTENT_NONE) return btn;
        if (pol.button_known && pol.button_down) pol.last_activity_time = it.time_ms;
        if (it.wrist_lift && !pol.display_on_state && !pol.selftest_running &&
            !(pol.button_known && pol.button_down)) begin
            pol.last_activity_time = it.time_ms;
            pol.display_on_state   = 1'b1;
            return INTENT_WAKE;
        end
        // wrapped difference, a clock that went backwards counts as no idle time
        idle = it.time_ms - pol.last_activity_time;
        if (idle[63]) idle = 64'd0;
        if (pol.display_on_state && !pol.selftest_running && idle >= active_limit()) begin
            pol.display_on_state = 1'b0;
            return INTENT_SLEEP;
        end
        return INTENT_NONE;
    endfunction

    function automatic t_out_item predict_result(input t_in_item it);
        t_out_item r;
        r.intent = INTENT_NONE;
        case (it.kind)
            KIND_STEP: r.intent = policy_intent(it);
            KIND_PAIRING: begin
                if (pol.pairing_page_active != it.flag_value) begin
                    pol.pairing_page_active = it.flag_value;
                    pol.last_activity_time  = it.time_ms;
                end
            end
            KIND_RECONCILE: pol.display_on_state = it.flag_value;
            default: begin
                if (pol.selftest_running && !pol.display_on_state)
                    pol.selftest_wake_blocked = 1'b1;
            end
        endcase
        r.display_is_on = pol.display_on_state;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            pol                  = '0;
            pol.display_on_state = INIT_ON_RESET;
            choice_q             = CHOICE_RESET;
            pair_to_q            = PAIRING_TO_RESET;
            init_on_q            = INIT_ON_RESET;
            expected_q.delete();
            errors               = 0;
            checked              = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result with nothing expected: intent %0d display %0b",
                             $time, i_out_data.intent, i_out_data.display_is_on);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    checked++;
                    if (i_out_data.intent !== want.intent) begin
                        $display("%0t: intent expected %0d actual %0d",
                                 $time, want.intent, i_out_data.intent);
                        errors++;
                    end
                    if (i_out_data.display_is_on !== want.display_is_on) begin
                        $display("%0t: display_is_on expected %0b actual %0b",
                                 $time, want.display_is_on, i_out_data.display_is_on);
                        errors++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IDLE_CHOICE: if (i_cfg_data[1:0] <= TO_30S) choice_q = i_cfg_data[1:0];
                    CFG_PAIRING_TO:  pair_to_q = i_cfg_data;
                    CFG_INIT_DISPLAY: begin
                        init_on_q            = i_cfg_data[0];
                        pol.display_on_state = i_cfg_data[0];
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) expected_q.push_back(predict_result(i_in_data));
        end
        o_fail_count  <= errors;
        o_outstanding <= expected_q.size();
        o_checked     <= checked;
    end

endmodule

`default_nettype wire

// ===== verif/tb_display_wake_sleep_policy.sv =====
// testbench top for display_wake_sleep_policy: clock, reset, stimulus, config phases, verdict
// depends on dwsp_pkg, the block and dwsp_policy_checker
`default_nettype none

module tb_display_wake_sleep_policy;
    import dwsp_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASE_ITEMS  = 215;
    localparam int HOLD_CYCLES  = 300;

    // unused timeout choice, a write of it must leave the register alone
    localparam logic [1:0] TO_UNUSED = 2'd3;

    // step fact bits, packed as {stop, st_valid, st_on, activity, btn_valid, btn_pressed, wrist}
    localparam logic [6:0] F_NONE = 7'b0000000;
    localparam logic [6:0] F_STOP = 7'b1000000;
    localparam logic [6:0] F_STV  = 7'b0100000;
    localparam logic [6:0] F_STON = 7'b0010000;
    localparam logic [6:0] F_ACT  = 7'b0001000;
    localparam logic [6:0] F_BV   = 7'b0000100;
    localparam logic [6:0] F_BP   = 7'b0000010;
    localparam logic [6:0] F_WR   = 7'b0000001;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       item_valid;
    logic       item_ready;
    t_in_item   item_data;
    logic       res_valid;
    logic       res_ready;
    t_out_item  res_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    int fail_count;
    int outstanding;
    int checked;
    int cycles = 0;
    int items_sent = 0;
    int reg_writes = 0;

    // shared pacing knobs: calm turns off idling on both sides, hold_req asks for a long stall
    logic calm = 1'b0;
    logic hold_req = 1'b0;

    // random stream state: running clock, held button level, held self-test level
    logic [63:0] now_ms;
    logic        btn_level;
    logic        st_level;

    always #2 clk = ~clk;

    display_wake_sleep_policy u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (item_valid),
        .o_in_ready  (item_ready),
        .i_in_data   (item_data),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_out_data  (res_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    dwsp_policy_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (item_valid),
        .i_in_ready    (item_ready),
        .i_in_data     (item_data),
        .i_out_valid   (res_valid),
        .i_out_ready   (res_ready),
        .i_out_data    (res_data),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    // watchdog, sized well above the slowest legal run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still expected", cycles, outstanding);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic t_in_item make_item(input logic [1:0] k, input logic [63:0] t,
                                           input logic [6:0] facts, input logic flag);
        t_in_item it;
        it.kind    = k;
        it.time_ms = t;
        {it.stop_request, it.selftest_known, it.selftest_on, it.user_activity,
         it.button_valid, it.button_pressed, it.wrist_lift} = facts;
        it.flag_value = flag;
        return it;
    endfunction

    // random item: mostly steps on a forward-moving clock with held button and
    // self-test levels, plus page, reconcile and failure kinds with noise in unused fields
    function automatic t_in_item next_random(input logic allow_stop);
        t_in_item it;
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)      now_ms = now_ms + 64'($urandom_range(0, 4000));
        else if (r < 85) now_ms = now_ms + 64'($urandom_range(4000, 40000));
        else if (r < 92) now_ms = now_ms + 64'($urandom_range(0, 70000));
        else if (r < 96) now_ms = now_ms - 64'($urandom_range(1, 100000));   // clock backwards
        else if (r < 98) now_ms = now_ms + {32'($urandom), 32'($urandom)};
        else             now_ms = {32'($urandom), 32'($urandom)};
        it = make_item(KIND_STEP, now_ms, 7'($urandom), 1'($urandom));
        r = $urandom_range(0, 99);
        if (r >= 70) begin
            it.kind = (r < 80) ? KIND_PAIRING : (r < 90) ? KIND_RECONCILE : KIND_FAILURE;
            return it;
        end
        it.stop_request = allow_stop && ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 15) == 0) begin
            it.button_valid = 1'b0;
        end else begin
            if ($urandom_range(0, 2) == 0) btn_level = ~btn_level;
            it.button_valid   = 1'b1;
            it.button_pressed = btn_level;
        end
        it.selftest_known = ($urandom_range(0, 4) == 0);
        if (it.selftest_known) begin
            if ($urandom_range(0, 1) == 0) st_level = ~st_level;
            it.selftest_on = st_level;
        end
        it.user_activity = ($urandom_range(0, 5) == 0);
        it.wrist_lift    = ($urandom_range(0, 4) == 0);
        return it;
    endfunction

    // offer one item, valid stays up until taken
    task automatic put_item(input t_in_item it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item_data  <= it;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        items_sent++;
    endtask

    // stop offering and wait for every expected result
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    // all three registers, with junk in the bits above the idle choice and initial display fields
    task automatic set_config(input logic [1:0] choice, input logic [15:0] pair_to,
                              input logic init_on);
        logic [15:0] noise;
        noise = 16'($urandom);
        write_reg(CFG_IDLE_CHOICE, {noise[15:2], choice});
        write_reg(CFG_PAIRING_TO, pair_to);
        noise = 16'($urandom);
        write_reg(CFG_INIT_DISPLAY, {noise[15:1], init_on});
    endtask

    task automatic run_random(input int n, input logic allow_stop);
        for (int i = 0; i < n; i++) put_item(next_random(allow_stop));
    endtask

    // result side: random stall per item, plus one long hold-off on request
    initial begin
        int w;
        res_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            w = calm ? 0 : $urandom_range(0, 8);
            if (w > 0) begin
                res_ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid) @(posedge clk);
        end
    end

    initial begin
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item_data  <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_IDLE_CHOICE;
        cfg_data   <= '0;
        btn_level  = 1'b0;
        st_level   = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed walk on reset settings: 15 s idle, 30 s pairing page, display on
        put_item(make_item(KIND_STEP, 64'd0, F_NONE, 1'b0));            // fresh, nothing due
        put_item(make_item(KIND_STEP, 64'd15000, F_NONE, 1'b0));        // exactly at timeout
        put_item(make_item(KIND_STEP, 64'd16000, F_WR, 1'b0));          // wrist wakes
        put_item(make_item(KIND_STEP, 64'd17000, F_BV, 1'b0));          // button becomes known
        put_item(make_item(KIND_STEP, 64'd17500, F_BV | F_BP, 1'b0));   // press with display on
        put_item(make_item(KIND_STEP, 64'd18000, F_BV | F_WR, 1'b1));   // release gives next page
        put_item(make_item(KIND_STEP, 64'd19000, F_STV | F_STON, 1'b0)); // self-test entry
        put_item(make_item(KIND_RECONCILE, 64'd19100, F_NONE, 1'b0));   // panel says off
        put_item(make_item(KIND_FAILURE, 64'd19200, F_NONE, 1'b0));     // blocks self-test wake
        put_item(make_item(KIND_STEP, 64'd19500, F_NONE, 1'b0));        // stays dark
        put_item(make_item(KIND_STEP, 64'd20000, F_ACT | F_BV | F_BP, 1'b0)); // user during test
        put_item(make_item(KIND_STEP, 64'd21000, F_STV | F_BV, 1'b0));  // self-test exit
        put_item(make_item(KIND_PAIRING, 64'd21000, F_NONE, 1'b1));     // page on
        put_item(make_item(KIND_STEP, 64'd51000, F_BV, 1'b0));          // pairing timeout
        put_item(make_item(KIND_PAIRING, 64'd51500, F_NONE, 1'b1));     // page unchanged
        put_item(make_item(KIND_PAIRING, 64'd52000, F_NONE, 1'b0));     // page off
        put_item(make_item(KIND_STEP, 64'd40000, F_BV | F_BP, 1'b0));   // backwards, press while off
        put_item(make_item(KIND_STEP, 64'd40100, F_BV, 1'b0));          // release wakes
        put_item(make_item(KIND_STEP, '1, F_ACT, 1'b0));                // all-ones time
        put_item(make_item(KIND_STEP, 64'h7FFF_FFFF_FFFF_FFFF, F_NONE, 1'b0));
        put_item(make_item(KIND_STEP, 64'd0, F_STV | F_STON | F_BV | F_BP, 1'b0));
        put_item(make_item(KIND_RECONCILE, 64'd10, F_NONE, 1'b1));
        put_item(make_item(KIND_STEP, 64'd20, F_STV | F_ACT | F_WR, 1'b0));
        put_item(make_item(KIND_FAILURE, '1, 7'h7F, 1'b1));
        now_ms = 64'd100000;

        // fastest timeout, 1 ms pairing page, start dark
        drain();
        set_config(TO_5S, 16'd1, 1'b0);
        run_random(PHASE_ITEMS, 1'b0);

        // full speed with a long result hold-off, so the block backs up onto its input
        drain();
        set_config(TO_30S, 16'hFFFF, 1'b1);
        calm     = 1'b1;
        hold_req = 1'b1;
        run_random(PHASE_ITEMS, 1'b0);
        calm = 1'b0;

        // unused choice code is dropped, pairing timeout zero, unused register index
        drain();
        set_config(TO_UNUSED, 16'd0, 1'b0);
        write_reg(CFG_UNUSED, 16'($urandom));
        run_random(PHASE_ITEMS, 1'b0);

        for (int p = 0; p < 4; p++) begin
            drain();
            set_config(2'($urandom_range(0, 3)),
                       ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(1, 20000)),
                       1'($urandom));
            calm = ($urandom_range(0, 2) == 0);
            run_random(PHASE_ITEMS, 1'b0);
        end
        calm = 1'b0;

        // stop near the end since only reset clears it, then everything after it
        run_random(10, 1'b0);
        put_item(make_item(KIND_STEP, now_ms, F_STOP, 1'b0));
        put_item(make_item(KIND_STEP, now_ms + 64'd100000, F_ACT | F_WR | F_BV, 1'b0));
        run_random(12, 1'b1);

        drain();
        repeat (8) @(posedge clk);
        $display("covered %0d items and %0d register writes; %0d results compared in %0d cycles",
                 items_sent, reg_writes, checked, cycles);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
